// ===== rtl/positional_list_insert_delete_assert.svh =====
// Assertion macros for the positional list block.
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define PLID_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("positional list invariant violated");

// Whenever the first condition holds, the second holds in the same cycle.
`define PLID_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional list implication violated");

`endif

// ===== rtl/plid_pkg.sv =====
// Shared types and constants of the positional list block.
package plid_pkg;

  localparam int FUNC_W   = 2;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 6;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]          func;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic                       has_value;
    logic signed [VALUE_W-1:0]  item_value;
    logic [TOTAL_W-1:0]         entry_total;
    logic                       last;
  } rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic [POS_W-1:0]           pos;
    logic [TOTAL_W-1:0]         count;
    logic signed [VALUE_W-1:0]  value;
  } cell_cmd_t;

endpackage

// ===== rtl/plid_cell.sv =====
// One storage cell of the list chain, shifting toward either neighbor on command.
module plid_cell #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  plid_pkg::cell_cmd_t                cmd,
  input  logic signed [plid_pkg::VALUE_W-1:0] left,
  input  logic signed [plid_pkg::VALUE_W-1:0] right,
  input  logic signed [plid_pkg::VALUE_W-1:0] front,
  output logic signed [plid_pkg::VALUE_W-1:0] q
);
  import plid_pkg::*;

  localparam logic [POS_W:0] SLOT = (POS_W + 1)'(IDX + 1);

  logic [POS_W:0] pos_x;
  logic [POS_W:0] count_x;

  assign pos_x   = {1'b0, cmd.pos};
  assign count_x = (POS_W + 1)'(cmd.count);

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: begin
        if (SLOT == pos_x) begin
          q <= cmd.value;
        end else if (SLOT > pos_x) begin
          q <= left;
        end
      end
      CELL_DELETE: begin
        if (SLOT >= pos_x) begin
          q <= right;
        end
      end
      CELL_ROTATE: begin
        if (SLOT < count_x) begin
          q <= right;
        end else if (SLOT == count_x) begin
          q <= front;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/positional_list_insert_delete.sv =====
// Positional list top level: a chain of cells with command decode and a result register.
// Insert and delete: the word is accepted and its status word is ready in the next cycle.
// Dump of N entries: N words, one per cycle if unstalled; each word rotates the chain left by one.
// Input is stalled while a dump runs and whenever the result register is full and stalled.
// Synchronous reset empties the list; cell contents are not cleared.
module positional_list_insert_delete #(
  parameter int DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  plid_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output plid_pkg::rsp_t rsp
);
  import plid_pkg::*;

  `include "positional_list_insert_delete_assert.svh"

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    dcnt;
  logic [CW-1:0]    dcnt_next;
  logic             load;
  rsp_t             rsp_next;
  cell_cmd_t        cmd;
  logic             adv;
  logic             acc;
  logic [POS_W:0]   pos_x;
  logic [POS_W:0]   count_x;
  logic signed [VALUE_W-1:0] cells [DEPTH];

  assign adv       = !rsp_valid || !rsp_stall;
  assign req_stall = (state == ST_DUMP) || !adv;
  assign acc       = req_valid && !req_stall;
  assign pos_x     = {1'b0, req.position};
  assign count_x   = (POS_W + 1)'(count);

  always_comb begin
    state_next           = state;
    count_next           = count;
    dcnt_next            = dcnt;
    load                 = 1'b0;
    cmd.op               = CELL_HOLD;
    cmd.pos              = req.position;
    cmd.count            = TOTAL_W'(count);
    cmd.value            = req.value;
    rsp_next.status      = STATUS_OK;
    rsp_next.has_value   = 1'b0;
    rsp_next.item_value  = '0;
    rsp_next.entry_total = TOTAL_W'(count);
    rsp_next.last        = 1'b1;
    if (acc) begin
      case (req.func)
        FUNC_INSERT: begin
          load = 1'b1;
          if (req.position == '0 || pos_x > count_x + (POS_W + 1)'(1)) begin
            rsp_next.status = STATUS_RANGE;
          end else if (count == CW'(DEPTH)) begin
            rsp_next.status = STATUS_FULL;
          end else begin
            cmd.op               = CELL_INSERT;
            count_next           = count + CW'(1);
            rsp_next.entry_total = TOTAL_W'(count_next);
          end
        end
        FUNC_DELETE: begin
          load = 1'b1;
          if (req.position == '0 || pos_x > count_x) begin
            rsp_next.status = STATUS_RANGE;
          end else begin
            cmd.op               = CELL_DELETE;
            count_next           = count - CW'(1);
            rsp_next.entry_total = TOTAL_W'(count_next);
          end
        end
        FUNC_DUMP: begin
          load = 1'b1;
          if (count != '0) begin
            cmd.op              = CELL_ROTATE;
            rsp_next.has_value  = 1'b1;
            rsp_next.item_value = cells[0];
            rsp_next.last       = (count == CW'(1));
            if (count != CW'(1)) begin
              state_next = ST_DUMP;
              dcnt_next  = CW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end else if (state == ST_DUMP && adv) begin
      load                = 1'b1;
      cmd.op              = CELL_ROTATE;
      rsp_next.has_value  = 1'b1;
      rsp_next.item_value = cells[0];
      rsp_next.last       = (dcnt + CW'(1) == count);
      dcnt_next           = dcnt + CW'(1);
      if (dcnt + CW'(1) == count) begin
        state_next = ST_IDLE;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VALUE_W-1:0] left_w;
    logic signed [VALUE_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = cmd.value;
    end else begin : g_mid_l
      assign left_w = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign right_w = cells[g];
    end else begin : g_mid_r
      assign right_w = cells[g+1];
    end
    plid_cell #(
      .IDX(g)
    ) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .left (left_w),
      .right(right_w),
      .front(cells[0]),
      .q    (cells[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dcnt      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      dcnt  <= dcnt_next;
      if (adv) begin
        rsp_valid <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= rsp_next;
    end
  end

  `PLID_ASSERT_ALWAYS(a_count_range, count <= CW'(DEPTH))
  `PLID_ASSERT_IMPLY(a_dump_index, state == ST_DUMP, dcnt < count && dcnt != '0)
  `PLID_ASSERT_IMPLY(a_nonlast_in_dump, rsp_valid && !rsp.last, state == ST_DUMP)

endmodule

// ===== dv/positional_list_insert_delete_tb.sv =====
// Self-checking testbench for the positional list covering edges, full list and backpressure.
module positional_list_insert_delete_tb;
  import plid_pkg::*;

  localparam int DEPTH = 32;
  localparam int IDLE_LIMIT = 1000;
  localparam int LONG_HOLD = 80;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  positional_list_insert_delete #(.DEPTH(DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  logic signed [VALUE_W-1:0] list_model [DEPTH];
  int list_len;
  rsp_t expected_rsp_q[$];

  int err_count;
  int n_insert, n_delete, n_dump, n_ignored, n_words;
  int n_range, n_full, peak_len;
  int idle_cycles;
  bit idle_en;
  bit stall_en;
  bit long_hold_req;
  int stall_left;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Updates the list copy for one accepted word and queues the words it should produce.
  task automatic apply_list_op(input req_t w);
    rsp_t r;
    int p;
    r = '0;
    r.last = 1'b1;
    p = int'(w.position);
    case (w.func)
      FUNC_INSERT: begin
        n_insert++;
        if (p == 0 || p > list_len + 1) begin
          r.status = STATUS_RANGE;
          n_range++;
        end else if (list_len >= DEPTH) begin
          r.status = STATUS_FULL;
          n_full++;
        end else begin
          for (int i = list_len; i >= p; i--) list_model[i] = list_model[i-1];
          list_model[p-1] = w.value;
          list_len++;
          if (list_len > peak_len) peak_len = list_len;
        end
        r.entry_total = TOTAL_W'(list_len);
        expected_rsp_q.push_back(r);
      end
      FUNC_DELETE: begin
        n_delete++;
        if (p == 0 || p > list_len) begin
          r.status = STATUS_RANGE;
          n_range++;
        end else begin
          for (int i = p - 1; i + 1 < list_len; i++) list_model[i] = list_model[i+1];
          list_len--;
        end
        r.entry_total = TOTAL_W'(list_len);
        expected_rsp_q.push_back(r);
      end
      FUNC_DUMP: begin
        n_dump++;
        if (list_len == 0) begin
          expected_rsp_q.push_back(r);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            r.status = STATUS_OK;
            r.has_value = 1'b1;
            r.item_value = list_model[i];
            r.entry_total = TOTAL_W'(list_len);
            r.last = (i == list_len - 1);
            expected_rsp_q.push_back(r);
          end
        end
      end
      default: begin
        n_ignored++;
      end
    endcase
  endtask

  function automatic int sender_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic req_t make_word(input logic [FUNC_W-1:0] f, input int p,
                                     input logic signed [VALUE_W-1:0] v);
    req_t w;
    w.func = f;
    w.position = POS_W'(p);
    w.value = v;
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input req_t w);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = w;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    apply_list_op(w);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    req_valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic req_t random_word();
    req_t w;
    int r;
    int ins_pct;
    w.value = $urandom();
    r = $urandom_range(0, 99);
    ins_pct = (list_len < DEPTH / 2) ? 55 : 35;
    if (r < 3) w.func = FUNC_UNUSED;
    else if (r < 13) w.func = FUNC_DUMP;
    else if (r < 13 + ins_pct) w.func = FUNC_INSERT;
    else w.func = FUNC_DELETE;
    if ($urandom_range(0, 99) < 15) w.position = POS_W'($urandom_range(0, 63));
    else if (w.func == FUNC_INSERT) w.position = POS_W'($urandom_range(1, list_len + 1));
    else if (list_len == 0) w.position = POS_W'($urandom_range(0, 63));
    else w.position = POS_W'($urandom_range(1, list_len));
    return w;
  endfunction

  // Receiver: random stalls, plus one long hold counted here on request.
  initial begin
    rsp_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (long_hold_req) begin
        stall_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (stall_en && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end
      rsp_stall = (stall_left > 0);
    end
  end

  always @(posedge clk) begin : check_results
    rsp_t exp_w;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_words++;
      if (expected_rsp_q.size() == 0) begin
        $error("Result word arrived with no expected word pending.");
        err_count++;
      end else begin
        exp_w = expected_rsp_q.pop_front();
        if (rsp.status !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, rsp.status);
          err_count++;
        end
        if (rsp.has_value !== exp_w.has_value) begin
          $error("has_value: expected %0d, got %0d", exp_w.has_value, rsp.has_value);
          err_count++;
        end
        if (rsp.item_value !== exp_w.item_value) begin
          $error("item_value: expected %0d, got %0d", exp_w.item_value, rsp.item_value);
          err_count++;
        end
        if (rsp.entry_total !== exp_w.entry_total) begin
          $error("entry_total: expected %0d, got %0d", exp_w.entry_total, rsp.entry_total);
          err_count++;
        end
        if (rsp.last !== exp_w.last) begin
          $error("last: expected %0d, got %0d", exp_w.last, rsp.last);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired with %0d words outstanding.", expected_rsp_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_empty_and_edges();
    send_word(make_word(FUNC_DUMP, 0, 0));
    send_word(make_word(FUNC_DELETE, 1, 0));
    send_word(make_word(FUNC_DELETE, 0, 0));
    send_word(make_word(FUNC_INSERT, 0, 5));
    send_word(make_word(FUNC_INSERT, 2, 5));
    send_word(make_word(FUNC_UNUSED, 1, 7));
    send_word(make_word(FUNC_INSERT, 1, 32'sh8000_0000));
    send_word(make_word(FUNC_INSERT, 2, 32'sh7fff_ffff));
    send_word(make_word(FUNC_INSERT, 1, -1));
    send_word(make_word(FUNC_INSERT, 4, 0));
    send_word(make_word(FUNC_DUMP, 63, -1));
    send_word(make_word(FUNC_DELETE, 2, 0));
    send_word(make_word(FUNC_DELETE, 63, 0));
    send_word(make_word(FUNC_INSERT, 63, 1));
    send_word(make_word(FUNC_DELETE, 3, 0));
    send_word(make_word(FUNC_DELETE, 1, 0));
    send_word(make_word(FUNC_DUMP, 0, 0));
    wait_drain();
  endtask

  task automatic test_full_list();
    idle_en = 1'b0;
    while (list_len < DEPTH)
      send_word(make_word(FUNC_INSERT, $urandom_range(1, list_len + 1), $urandom()));
    send_word(make_word(FUNC_INSERT, 1, 3));
    send_word(make_word(FUNC_INSERT, DEPTH + 1, 3));
    send_word(make_word(FUNC_INSERT, 0, 3));
    send_word(make_word(FUNC_INSERT, DEPTH + 2, 3));
    send_word(make_word(FUNC_DUMP, 0, 0));
    send_word(make_word(FUNC_DELETE, DEPTH + 1, 0));
    send_word(make_word(FUNC_DELETE, DEPTH, 0));
    send_word(make_word(FUNC_DELETE, 1, 0));
    idle_en = 1'b1;
    wait_drain();
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    long_hold_req = 1'b1;
    send_word(make_word(FUNC_DUMP, 0, 0));
    repeat (20) send_word(random_word());
    wait_drain();
    idle_en = 1'b1;
  endtask

  task automatic test_random_ops();
    for (int i = 0; i < 75; i++) begin
      if (i % 25 == 0) begin
        idle_en = (i != 50) && $urandom_range(0, 1);
        stall_en = (i != 50) && $urandom_range(0, 1);
      end
      send_word(random_word());
    end
    idle_en = 1'b1;
    stall_en = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    err_count = 0;
    list_len = 0;
    peak_len = 0;
    idle_en = 1'b1;
    stall_en = 1'b1;
    long_hold_req = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    test_empty_and_edges();
    test_full_list();
    test_backpressure();
    test_random_ops();
    wait_drain();
    repeat (10) @(posedge clk);

    $display("Sent %0d inserts, %0d deletes, %0d dumps and %0d unused codes; checked %0d words.",
             n_insert, n_delete, n_dump, n_ignored, n_words);
    $display("Saw %0d range errors and %0d full-list rejections; peak list size %0d of %0d.",
             n_range, n_full, peak_len, DEPTH);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
